FILE: rtl/core/assert_macros.svh
// assertion macros shared by the interface register file rtl
// expects a clock named clk and a synchronous active-high reset named rst in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// combinational property checked at every clock edge out of reset
`define VIA_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error(msg);

// property whose consequent is checked in the cycle after the antecedent
`define VIA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/via_rf_pkg.sv
// types and codes for the 6522-style interface register file
// no dependencies; used by versatile_interface_register_file
package via_rf_pkg;

  // request commands
  typedef enum logic [2:0] {
    CMD_READ   = 3'd0,
    CMD_WRITE  = 3'd1,
    CMD_PORT_A = 3'd2,
    CMD_PORT_B = 3'd3,
    CMD_CA1    = 3'd4,
    CMD_CA2    = 3'd5,
    CMD_CB1    = 3'd6,
    CMD_CB2    = 3'd7
  } cmd_t;

  // register offsets, standard 6522 order
  typedef enum logic [3:0] {
    REG_ORB    = 4'd0,
    REG_ORA    = 4'd1,
    REG_DDRB   = 4'd2,
    REG_DDRA   = 4'd3,
    REG_T1C_L  = 4'd4,
    REG_T1C_H  = 4'd5,
    REG_T1L_L  = 4'd6,
    REG_T1L_H  = 4'd7,
    REG_T2C_L  = 4'd8,
    REG_T2C_H  = 4'd9,
    REG_SR     = 4'd10,
    REG_ACR    = 4'd11,
    REG_PCR    = 4'd12,
    REG_IFR    = 4'd13,
    REG_IER    = 4'd14,
    REG_ORA_NH = 4'd15
  } reg_t;

  // interrupt flag bits
  localparam logic [7:0] FLAG_CA2 = 8'h01;
  localparam logic [7:0] FLAG_CA1 = 8'h02;
  localparam logic [7:0] FLAG_SR  = 8'h04;
  localparam logic [7:0] FLAG_CB2 = 8'h08;
  localparam logic [7:0] FLAG_CB1 = 8'h10;
  localparam logic [7:0] FLAG_T2  = 8'h20;
  localparam logic [7:0] FLAG_T1  = 8'h40;
  localparam logic [7:0] FLAG_IRQ = 8'h80;

  localparam logic [15:0] TIMER_RESET = 16'hFFFF;

  typedef struct packed {
    logic [2:0] cmd;
    logic [3:0] reg_index;
    logic [7:0] data;
  } in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq;
    logic [7:0] port_a_pins;
    logic       port_a_notify;
    logic [7:0] port_b_pins;
    logic       port_b_notify;
  } out_t;

endpackage

FILE: rtl/core/versatile_interface_register_file.sv
// 6522-style interface adapter register side: bus registers, pin events, interrupt line
// depends on via_rf_pkg and assert_macros.svh
// a request is held in an input register; its result goes into the result slot as soon
// as that slot is empty or being taken, so a held result stalls the request
// throughput: one request per cycle unless the output stalls; one pass of register logic
// reset: rst clears both slot valid flags and resets every architectural register
`include "assert_macros.svh"

module versatile_interface_register_file (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  via_rf_pkg::in_t   in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output via_rf_pkg::out_t  out_item
);

  // pipeline slots
  logic             pend_valid;
  via_rf_pkg::in_t  pend_item;
  logic             advance;

  // architectural registers
  logic [7:0]  out_reg_a, out_reg_b, dir_a, dir_b, in_pins_a, in_pins_b;
  logic [7:0]  t1_latch_lo, t1_latch_hi;
  logic [15:0] t1_count, t2_latch_word, t2_count;
  logic        t2_running;
  logic [7:0]  shift_value, aux_control, periph_control, int_flags;
  logic [6:0]  int_enables;
  logic [7:0]  out_a_nh;
  logic [3:0]  line_levels;

  logic [7:0]  out_reg_a_next, out_reg_b_next, dir_a_next, dir_b_next;
  logic [7:0]  in_pins_a_next, in_pins_b_next, t1_latch_lo_next, t1_latch_hi_next;
  logic [15:0] t1_count_next, t2_latch_word_next, t2_count_next;
  logic        t2_running_next;
  logic [7:0]  shift_value_next, aux_control_next, periph_control_next, int_flags_next;
  logic [6:0]  int_enables_next;
  logic [7:0]  out_a_nh_next;
  logic [3:0]  line_levels_next;

  via_rf_pkg::out_t result;
  logic             force_b;
  logic [7:0]       old_a, old_b, new_a, new_b;
  logic             lvl, old_lvl;
  logic [15:0]      t2_dec;

  // edge detect for a control line; mode 0-1 falling, 2-3 rising, else none
  function automatic logic line_edge(input logic [2:0] mode, input logic was,
                                     input logic now);
    logic hit;
    begin
      hit = 1'b0;
      if (mode <= 3'd1) begin
        hit = was & ~now;
      end else if (mode <= 3'd3) begin
        hit = ~was & now;
      end
      return hit;
    end
  endfunction

  // handshake: the input slot refills while the result slot moves on
  assign advance  = pend_valid && (!out_valid || out_ready);
  assign in_ready = !pend_valid || advance;

  // register update for the request in the input slot
  always_comb begin
    out_reg_a_next      = out_reg_a;
    out_reg_b_next      = out_reg_b;
    dir_a_next          = dir_a;
    dir_b_next          = dir_b;
    in_pins_a_next      = in_pins_a;
    in_pins_b_next      = in_pins_b;
    t1_latch_lo_next    = t1_latch_lo;
    t1_latch_hi_next    = t1_latch_hi;
    t1_count_next       = t1_count;
    t2_latch_word_next  = t2_latch_word;
    t2_count_next       = t2_count;
    t2_running_next     = t2_running;
    shift_value_next    = shift_value;
    aux_control_next    = aux_control;
    periph_control_next = periph_control;
    int_flags_next      = int_flags;
    int_enables_next    = int_enables;
    out_a_nh_next       = out_a_nh;
    line_levels_next    = line_levels;
    force_b             = 1'b0;
    result.read_data    = 8'h00;
    lvl                 = pend_item.data[0];
    old_lvl             = line_levels[pend_item.cmd[1:0]];
    t2_dec              = t2_count - 16'd1;

    case (pend_item.cmd)
      via_rf_pkg::CMD_READ: begin
        case (pend_item.reg_index)
          via_rf_pkg::REG_ORB: begin
            int_flags_next   = int_flags & ~(via_rf_pkg::FLAG_CB1 | via_rf_pkg::FLAG_CB2);
            result.read_data = (in_pins_b & ~dir_b) | (out_reg_b & dir_b);
          end
          via_rf_pkg::REG_ORA: begin
            int_flags_next   = int_flags & ~(via_rf_pkg::FLAG_CA1 | via_rf_pkg::FLAG_CA2);
            result.read_data = (in_pins_a & ~dir_a) | (out_reg_a & dir_a);
          end
          via_rf_pkg::REG_DDRB:  result.read_data = dir_b;
          via_rf_pkg::REG_DDRA:  result.read_data = dir_a;
          via_rf_pkg::REG_T1C_L: begin
            int_flags_next   = int_flags & ~via_rf_pkg::FLAG_T1;
            result.read_data = t1_count[7:0];
          end
          via_rf_pkg::REG_T1C_H: result.read_data = t1_count[15:8];
          via_rf_pkg::REG_T1L_L: result.read_data = t1_latch_lo;
          via_rf_pkg::REG_T1L_H: result.read_data = t1_latch_hi;
          via_rf_pkg::REG_T2C_L: begin
            int_flags_next   = int_flags & ~via_rf_pkg::FLAG_T2;
            result.read_data = t2_count[7:0];
          end
          via_rf_pkg::REG_T2C_H: result.read_data = t2_count[15:8];
          via_rf_pkg::REG_SR: begin
            int_flags_next   = int_flags & ~via_rf_pkg::FLAG_SR;
            result.read_data = shift_value;
          end
          via_rf_pkg::REG_ACR:   result.read_data = aux_control;
          via_rf_pkg::REG_PCR:   result.read_data = periph_control;
          via_rf_pkg::REG_IFR:   result.read_data = int_flags;
          via_rf_pkg::REG_IER:   result.read_data = {1'b1, int_enables};
          default:               result.read_data = out_a_nh;
        endcase
      end
      via_rf_pkg::CMD_WRITE: begin
        case (pend_item.reg_index)
          via_rf_pkg::REG_ORB: begin
            out_reg_b_next = pend_item.data;
            int_flags_next = int_flags & ~(via_rf_pkg::FLAG_CB1 | via_rf_pkg::FLAG_CB2);
          end
          via_rf_pkg::REG_ORA: begin
            out_reg_a_next = pend_item.data;
            int_flags_next = int_flags & ~(via_rf_pkg::FLAG_CA1 | via_rf_pkg::FLAG_CA2);
          end
          via_rf_pkg::REG_DDRB:  dir_b_next = pend_item.data;
          via_rf_pkg::REG_DDRA:  dir_a_next = pend_item.data;
          via_rf_pkg::REG_T1C_L: t1_latch_lo_next = pend_item.data;
          // timer 1 start: load counter, clear pb7 when it drives the pin
          via_rf_pkg::REG_T1C_H: begin
            t1_latch_hi_next = pend_item.data;
            t1_count_next    = {pend_item.data, t1_latch_lo};
            int_flags_next   = int_flags & ~via_rf_pkg::FLAG_T1;
            if (aux_control[7] && dir_b[7]) begin
              out_reg_b_next = {1'b0, out_reg_b[6:0]};
              force_b        = 1'b1;
            end
          end
          via_rf_pkg::REG_T1L_L: t1_latch_lo_next = pend_item.data;
          via_rf_pkg::REG_T1L_H: begin
            t1_latch_hi_next = pend_item.data;
            int_flags_next   = int_flags & ~via_rf_pkg::FLAG_T1;
          end
          via_rf_pkg::REG_T2C_L: t2_latch_word_next = {t2_latch_word[15:8], pend_item.data};
          via_rf_pkg::REG_T2C_H: begin
            t2_latch_word_next = {pend_item.data, t2_latch_word[7:0]};
            t2_count_next      = {pend_item.data, t2_latch_word[7:0]};
            int_flags_next     = int_flags & ~via_rf_pkg::FLAG_T2;
            t2_running_next    = 1'b1;
          end
          via_rf_pkg::REG_SR: begin
            shift_value_next = pend_item.data;
            int_flags_next   = int_flags & ~via_rf_pkg::FLAG_SR;
          end
          via_rf_pkg::REG_ACR:   aux_control_next = pend_item.data;
          via_rf_pkg::REG_PCR:   periph_control_next = pend_item.data;
          via_rf_pkg::REG_IFR:   int_flags_next = int_flags & ~{1'b0, pend_item.data[6:0]};
          // bit 7 picks set or clear
          via_rf_pkg::REG_IER: begin
            if (pend_item.data[7]) begin
              int_enables_next = int_enables | pend_item.data[6:0];
            end else begin
              int_enables_next = int_enables & ~pend_item.data[6:0];
            end
          end
          default: begin
            out_a_nh_next  = pend_item.data;
            out_reg_a_next = pend_item.data;
          end
        endcase
      end
      via_rf_pkg::CMD_PORT_A: in_pins_a_next = pend_item.data;
      // port b input with pb6 pulse counting for timer 2
      via_rf_pkg::CMD_PORT_B: begin
        in_pins_b_next = pend_item.data;
        if (aux_control[5] && t2_running && in_pins_b[6] && !pend_item.data[6]) begin
          t2_count_next = t2_dec;
          if (t2_dec == via_rf_pkg::TIMER_RESET) begin
            int_flags_next  = int_flags | via_rf_pkg::FLAG_T2;
            t2_running_next = 1'b0;
          end
        end
      end
      via_rf_pkg::CMD_CA1: begin
        line_levels_next[0] = lvl;
        if (line_edge({1'b0, periph_control[0], 1'b0}, old_lvl, lvl)) begin
          int_flags_next = int_flags | via_rf_pkg::FLAG_CA1;
        end
      end
      via_rf_pkg::CMD_CA2: begin
        line_levels_next[1] = lvl;
        if (line_edge(periph_control[3:1], old_lvl, lvl)) begin
          int_flags_next = int_flags | via_rf_pkg::FLAG_CA2;
        end
      end
      via_rf_pkg::CMD_CB1: begin
        line_levels_next[2] = lvl;
        if (line_edge({1'b0, periph_control[4], 1'b0}, old_lvl, lvl)) begin
          int_flags_next = int_flags | via_rf_pkg::FLAG_CB1;
        end
      end
      default: begin
        line_levels_next[3] = lvl;
        if (line_edge(periph_control[7:5], old_lvl, lvl)) begin
          int_flags_next = int_flags | via_rf_pkg::FLAG_CB2;
        end
      end
    endcase

    // irq summary bit from flags and enables after the update
    int_flags_next[7] = |(int_flags_next[6:0] & int_enables_next);

    // pin bytes before and after
    old_a = (in_pins_a & ~dir_a) | (out_reg_a & dir_a);
    old_b = (in_pins_b & ~dir_b) | (out_reg_b & dir_b);
    new_a = (in_pins_a_next & ~dir_a_next) | (out_reg_a_next & dir_a_next);
    new_b = (in_pins_b_next & ~dir_b_next) | (out_reg_b_next & dir_b_next);

    result.irq           = int_flags_next[7];
    result.port_a_pins   = new_a;
    result.port_a_notify = new_a != old_a;
    result.port_b_pins   = new_b;
    result.port_b_notify = force_b || (new_b != old_b);
  end

  // pipeline slots and register file
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid     <= 1'b0;
      out_valid      <= 1'b0;
      out_reg_a      <= 8'h00;
      out_reg_b      <= 8'h00;
      dir_a          <= 8'h00;
      dir_b          <= 8'h00;
      in_pins_a      <= 8'h00;
      in_pins_b      <= 8'h00;
      t1_latch_lo    <= 8'h00;
      t1_latch_hi    <= 8'h00;
      t1_count       <= via_rf_pkg::TIMER_RESET;
      t2_latch_word  <= via_rf_pkg::TIMER_RESET;
      t2_count       <= via_rf_pkg::TIMER_RESET;
      t2_running     <= 1'b0;
      shift_value    <= 8'h00;
      aux_control    <= 8'h00;
      periph_control <= 8'h00;
      int_flags      <= 8'h00;
      int_enables    <= 7'h00;
      out_a_nh       <= 8'h00;
      line_levels    <= 4'hF;
    end else begin
      if (in_valid && in_ready) begin
        pend_valid <= 1'b1;
        pend_item  <= in_item;
      end else if (advance) begin
        pend_valid <= 1'b0;
      end
      if (advance) begin
        out_valid      <= 1'b1;
        out_item       <= result;
        out_reg_a      <= out_reg_a_next;
        out_reg_b      <= out_reg_b_next;
        dir_a          <= dir_a_next;
        dir_b          <= dir_b_next;
        in_pins_a      <= in_pins_a_next;
        in_pins_b      <= in_pins_b_next;
        t1_latch_lo    <= t1_latch_lo_next;
        t1_latch_hi    <= t1_latch_hi_next;
        t1_count       <= t1_count_next;
        t2_latch_word  <= t2_latch_word_next;
        t2_count       <= t2_count_next;
        t2_running     <= t2_running_next;
        shift_value    <= shift_value_next;
        aux_control    <= aux_control_next;
        periph_control <= periph_control_next;
        int_flags      <= int_flags_next;
        int_enables    <= int_enables_next;
        out_a_nh       <= out_a_nh_next;
        line_levels    <= line_levels_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // checks
  `VIA_ASSERT_ALWAYS(a_irq_summary, int_flags[7] == |(int_flags[6:0] & int_enables), "irq stale")
  `VIA_ASSERT_NEXT(a_advance_fills, advance, out_valid, "result slot empty after a move")
  `VIA_ASSERT_NEXT(a_pend_holds, pend_valid && !advance, pend_valid && $stable(pend_item), "lost")
  `VIA_ASSERT_NEXT(a_irq_matches, advance, out_item.irq == int_flags[7], "result irq differs")

endmodule

FILE: tb/sv/tb.sv
// self-checking testbench for the 6522-style interface register file
// depends on via_rf_pkg and versatile_interface_register_file; keeps its own
// register-level prediction and checks every response field against it
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;

  typedef enum logic [1:0] {SENSE_FALL, SENSE_RISE, SENSE_NONE} sense_t;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  via_rf_pkg::in_t  in_item;
  logic out_valid;
  logic out_ready;
  via_rf_pkg::out_t out_item;

  // predicted register state
  logic [7:0]  port_b_out, port_a_out, ddr_b, ddr_a, pin_in_a, pin_in_b;
  logic [7:0]  t1_latch_lo, t1_latch_hi, shift_value, acr, pcr, flags, ora_nh;
  logic [15:0] t1_counter, t2_latch, t2_counter;
  logic [6:0]  enables;
  logic        t2_counting;
  logic [3:0]  line_levels;

  via_rf_pkg::out_t pending_responses[$];
  int   errors = 0;
  int   hold_off_len = 0;
  logic steady = 1'b0;
  int unsigned cycle_count = 0;

  versatile_interface_register_file DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return $urandom_range(1, 3);
    if (r < 9) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] drive_pins(logic [7:0] pin_in, logic [7:0] out_val,
                                            logic [7:0] ddr);
    return (pin_in & ~ddr) | (out_val & ddr);
  endfunction

  // one request applied to the predicted registers, returns the response
  function automatic via_rf_pkg::out_t via_step(via_rf_pkg::in_t req);
    via_rf_pkg::out_t resp;
    logic [7:0] before_a, before_b, after_a, after_b, d, line_flag;
    logic       pb7_forced, old_level;
    logic [1:0] line;
    logic [2:0] mode;
    sense_t     sense;
    before_a = drive_pins(pin_in_a, port_a_out, ddr_a);
    before_b = drive_pins(pin_in_b, port_b_out, ddr_b);
    pb7_forced = 1'b0;
    resp = '0;
    d = req.data;
    case (via_rf_pkg::cmd_t'(req.cmd))
      via_rf_pkg::CMD_READ: begin
        case (via_rf_pkg::reg_t'(req.reg_index))
          via_rf_pkg::REG_ORB: begin
            flags &= ~(via_rf_pkg::FLAG_CB1 | via_rf_pkg::FLAG_CB2);
            resp.read_data = before_b;
          end
          via_rf_pkg::REG_ORA: begin
            flags &= ~(via_rf_pkg::FLAG_CA1 | via_rf_pkg::FLAG_CA2);
            resp.read_data = before_a;
          end
          via_rf_pkg::REG_DDRB:  resp.read_data = ddr_b;
          via_rf_pkg::REG_DDRA:  resp.read_data = ddr_a;
          via_rf_pkg::REG_T1C_L: begin
            flags &= ~via_rf_pkg::FLAG_T1;
            resp.read_data = t1_counter[7:0];
          end
          via_rf_pkg::REG_T1C_H: resp.read_data = t1_counter[15:8];
          via_rf_pkg::REG_T1L_L: resp.read_data = t1_latch_lo;
          via_rf_pkg::REG_T1L_H: resp.read_data = t1_latch_hi;
          via_rf_pkg::REG_T2C_L: begin
            flags &= ~via_rf_pkg::FLAG_T2;
            resp.read_data = t2_counter[7:0];
          end
          via_rf_pkg::REG_T2C_H: resp.read_data = t2_counter[15:8];
          via_rf_pkg::REG_SR: begin
            flags &= ~via_rf_pkg::FLAG_SR;
            resp.read_data = shift_value;
          end
          via_rf_pkg::REG_ACR:   resp.read_data = acr;
          via_rf_pkg::REG_PCR:   resp.read_data = pcr;
          via_rf_pkg::REG_IFR:   resp.read_data = flags;
          via_rf_pkg::REG_IER:   resp.read_data = {1'b1, enables};
          default:               resp.read_data = ora_nh;
        endcase
      end
      via_rf_pkg::CMD_WRITE: begin
        case (via_rf_pkg::reg_t'(req.reg_index))
          via_rf_pkg::REG_ORB: begin
            port_b_out = d;
            flags &= ~(via_rf_pkg::FLAG_CB1 | via_rf_pkg::FLAG_CB2);
          end
          via_rf_pkg::REG_ORA: begin
            port_a_out = d;
            flags &= ~(via_rf_pkg::FLAG_CA1 | via_rf_pkg::FLAG_CA2);
          end
          via_rf_pkg::REG_DDRB:  ddr_b = d;
          via_rf_pkg::REG_DDRA:  ddr_a = d;
          via_rf_pkg::REG_T1C_L: t1_latch_lo = d;
          via_rf_pkg::REG_T1C_H: begin
            // timer 1 start, pb7 drops when it is a timer output
            t1_latch_hi = d;
            t1_counter = {d, t1_latch_lo};
            flags &= ~via_rf_pkg::FLAG_T1;
            if (acr[7] && ddr_b[7]) begin
              port_b_out[7] = 1'b0;
              pb7_forced = 1'b1;
            end
          end
          via_rf_pkg::REG_T1L_L: t1_latch_lo = d;
          via_rf_pkg::REG_T1L_H: begin
            t1_latch_hi = d;
            flags &= ~via_rf_pkg::FLAG_T1;
          end
          via_rf_pkg::REG_T2C_L: t2_latch[7:0] = d;
          via_rf_pkg::REG_T2C_H: begin
            t2_latch[15:8] = d;
            t2_counter = t2_latch;
            flags &= ~via_rf_pkg::FLAG_T2;
            t2_counting = 1'b1;
          end
          via_rf_pkg::REG_SR: begin
            shift_value = d;
            flags &= ~via_rf_pkg::FLAG_SR;
          end
          via_rf_pkg::REG_ACR:   acr = d;
          via_rf_pkg::REG_PCR:   pcr = d;
          via_rf_pkg::REG_IFR:   flags &= ~{1'b0, d[6:0]};
          via_rf_pkg::REG_IER: begin
            if (d[7]) enables |= d[6:0];
            else enables &= ~d[6:0];
          end
          default: begin
            ora_nh = d;
            port_a_out = d;
          end
        endcase
      end
      via_rf_pkg::CMD_PORT_A: pin_in_a = d;
      via_rf_pkg::CMD_PORT_B: begin
        // pb6 falling edge counts timer 2 down in pulse counting mode
        if (acr[5] && t2_counting && pin_in_b[6] && !d[6]) begin
          t2_counter = t2_counter - 16'd1;
          if (t2_counter == via_rf_pkg::TIMER_RESET) begin
            flags |= via_rf_pkg::FLAG_T2;
            t2_counting = 1'b0;
          end
        end
        pin_in_b = d;
      end
      default: begin
        // control line level, flag on the active edge chosen by pcr
        line = req.cmd[1:0];
        old_level = line_levels[line];
        line_levels[line] = d[0];
        case (via_rf_pkg::cmd_t'(req.cmd))
          via_rf_pkg::CMD_CA1: begin
            sense = pcr[0] ? SENSE_RISE : SENSE_FALL;
            line_flag = via_rf_pkg::FLAG_CA1;
          end
          via_rf_pkg::CMD_CB1: begin
            sense = pcr[4] ? SENSE_RISE : SENSE_FALL;
            line_flag = via_rf_pkg::FLAG_CB1;
          end
          default: begin
            if (via_rf_pkg::cmd_t'(req.cmd) == via_rf_pkg::CMD_CA2) begin
              mode = pcr[3:1];
              line_flag = via_rf_pkg::FLAG_CA2;
            end else begin
              mode = pcr[7:5];
              line_flag = via_rf_pkg::FLAG_CB2;
            end
            // output modes have no active edge
            sense = (mode <= 3'd1) ? SENSE_FALL : (mode <= 3'd3) ? SENSE_RISE : SENSE_NONE;
          end
        endcase
        if ((sense == SENSE_FALL && old_level && !d[0]) ||
            (sense == SENSE_RISE && !old_level && d[0]))
          flags |= line_flag;
      end
    endcase
    // irq bit follows the enabled flags
    flags[7] = ((flags & {1'b0, enables}) != 8'h00);
    after_a = drive_pins(pin_in_a, port_a_out, ddr_a);
    after_b = drive_pins(pin_in_b, port_b_out, ddr_b);
    resp.irq = flags[7];
    resp.port_a_pins = after_a;
    resp.port_a_notify = (after_a != before_a);
    resp.port_b_pins = after_b;
    resp.port_b_notify = pb7_forced || (after_b != before_b);
    return resp;
  endfunction

  // offer one request, predict its response once accepted
  task automatic send_request(input via_rf_pkg::cmd_t op, input via_rf_pkg::reg_t idx,
                              input logic [7:0] value);
    via_rf_pkg::in_t req;
    req.cmd = op;
    req.reg_index = idx;
    req.data = value;
    in_item = req;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_responses.push_back(via_step(req));
    @(negedge clk);
    // accepted request is withdrawn; the next call raises valid again at once
    in_valid = 1'b0;
    if (!steady && $urandom_range(0, 3) == 0) begin
      repeat (pick_gap()) @(negedge clk);
    end
  endtask

  task automatic send_random_request();
    int               r;
    via_rf_pkg::cmd_t op;
    r = $urandom_range(0, 9);
    if (r < 3) op = via_rf_pkg::CMD_READ;
    else if (r < 6) op = via_rf_pkg::CMD_WRITE;
    else op = via_rf_pkg::cmd_t'($urandom_range(via_rf_pkg::CMD_PORT_A,
                                                via_rf_pkg::CMD_CB2));
    send_request(op, via_rf_pkg::reg_t'($urandom_range(via_rf_pkg::REG_ORB,
                                                       via_rf_pkg::REG_ORA_NH)),
                 8'($urandom_range(0, 255)));
  endtask

  task automatic wait_drained();
    while (pending_responses.size() != 0) @(negedge clk);
  endtask

  task automatic compare_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  // response checker
  always @(posedge clk) begin : check_responses
    via_rf_pkg::out_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_responses.size() == 0) begin
        $display("%0t: response with no request pending, expected none actual %h",
                 $time, out_item);
        errors++;
      end else begin
        want = pending_responses.pop_front();
        compare_field("read_data", want.read_data, out_item.read_data);
        compare_field("irq", 8'(want.irq), 8'(out_item.irq));
        compare_field("port_a_pins", want.port_a_pins, out_item.port_a_pins);
        compare_field("port_a_notify", 8'(want.port_a_notify), 8'(out_item.port_a_notify));
        compare_field("port_b_pins", want.port_b_pins, out_item.port_b_pins);
        compare_field("port_b_notify", 8'(want.port_b_notify), 8'(out_item.port_b_notify));
      end
    end
  end

  // response side: random stalls, plus a long hold-off on demand
  initial begin
    out_ready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      if (hold_off_len != 0) begin
        out_ready = 1'b0;
        repeat (hold_off_len) @(negedge clk);
        hold_off_len = 0;
      end else if (!steady && $urandom_range(0, 3) == 0) begin
        out_ready = 1'b0;
        repeat (pick_gap()) @(negedge clk);
      end else begin
        out_ready = 1'b1;
        @(negedge clk);
      end
    end
  end

  // port and direction registers, no-handshake alias, enable and flag writes
  task automatic test_bus_registers();
    send_request(via_rf_pkg::CMD_WRITE, via_rf_pkg::REG_DDRA, 8'hFF);
    send_request(via_rf_pkg::CMD_WRITE, via_rf_pkg::REG_ORA, 8'hA5);
    send_request(via_rf_pkg::CMD_WRITE, via_rf_pkg::REG_ORA_NH, 8'h5A);
    send_request(via_rf_pkg::CMD_READ, via_rf_pkg::REG_ORA_NH, 8'h00);
    send_request(via_rf_pkg::CMD_WRITE, via_rf_pkg::REG_IER, 8'hFF);
    send_request(via_rf_pkg::CMD_WRITE, via_rf_pkg::REG_IFR, 8'h7F);
    send_request(via_rf_pkg::CMD_READ, via_rf_pkg::REG_IER, 8'h00);
  endtask

  // input bytes and control line edges, including the ca2 output mode
  task automatic test_control_lines();
    send_request(via_rf_pkg::CMD_PORT_A, via_rf_pkg::REG_ORB, 8'hFF);
    send_request(via_rf_pkg::CMD_PORT_B, via_rf_pkg::REG_ORB, 8'hFF);
    send_request(via_rf_pkg::CMD_WRITE, via_rf_pkg::REG_PCR, 8'hEE);
    send_request(via_rf_pkg::CMD_CA1, via_rf_pkg::REG_ORB, 8'h00);
    send_request(via_rf_pkg::CMD_CA2, via_rf_pkg::REG_ORB, 8'h00);
    send_request(via_rf_pkg::CMD_CB1, via_rf_pkg::REG_ORB, 8'h00);
    send_request(via_rf_pkg::CMD_READ, via_rf_pkg::REG_ORA, 8'h00);
    send_request(via_rf_pkg::CMD_READ, via_rf_pkg::REG_ORB, 8'h00);
  endtask

  // pb7 clear on timer 1 start, pb6 pulse counting wrap, reads that clear flags
  task automatic test_timer_side_effects();
    send_request(via_rf_pkg::CMD_WRITE, via_rf_pkg::REG_ACR, 8'hA0);
    send_request(via_rf_pkg::CMD_WRITE, via_rf_pkg::REG_DDRB, 8'hFF);
    send_request(via_rf_pkg::CMD_WRITE, via_rf_pkg::REG_ORB, 8'hFF);
    send_request(via_rf_pkg::CMD_WRITE, via_rf_pkg::REG_T1C_H, 8'h12);
    send_request(via_rf_pkg::CMD_READ, via_rf_pkg::REG_T1C_L, 8'h00);
    send_request(via_rf_pkg::CMD_WRITE, via_rf_pkg::REG_T2C_L, 8'h01);
    send_request(via_rf_pkg::CMD_WRITE, via_rf_pkg::REG_T2C_H, 8'h00);
    send_request(via_rf_pkg::CMD_PORT_B, via_rf_pkg::REG_ORB, 8'h00);
    send_request(via_rf_pkg::CMD_PORT_B, via_rf_pkg::REG_ORB, 8'h40);
    send_request(via_rf_pkg::CMD_PORT_B, via_rf_pkg::REG_ORB, 8'h00);
    send_request(via_rf_pkg::CMD_READ, via_rf_pkg::REG_T2C_L, 8'h00);
    send_request(via_rf_pkg::CMD_READ, via_rf_pkg::REG_SR, 8'h00);
    send_request(via_rf_pkg::CMD_WRITE, via_rf_pkg::REG_IER, 8'h7F);
  endtask

  // output side held off while requests keep coming, so the input stalls
  task automatic test_backpressure();
    steady = 1'b1;
    hold_off_len = 80;
    repeat (24) send_random_request();
    wait_drained();
    steady = 1'b0;
  endtask

  // random traffic with pulse counting bursts and control line bursts mixed in
  task automatic test_random_traffic(input int count);
    int         sent, n, choice;
    logic       pb6_level;
    logic [7:0] v;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 49) == 0) steady = !steady;
      choice = $urandom_range(0, 9);
      if (choice == 0) begin
        // short timer 2 count driven by pb6 toggles
        send_request(via_rf_pkg::CMD_WRITE, via_rf_pkg::REG_ACR,
                     8'($urandom_range(0, 255)) | 8'h20);
        send_request(via_rf_pkg::CMD_WRITE, via_rf_pkg::REG_T2C_L,
                     8'($urandom_range(0, 3)));
        send_request(via_rf_pkg::CMD_WRITE, via_rf_pkg::REG_T2C_H, 8'h00);
        n = $urandom_range(2, 10);
        pb6_level = 1'($urandom_range(0, 1));
        repeat (n) begin
          v = 8'($urandom_range(0, 255));
          v[6] = pb6_level;
          pb6_level = !pb6_level;
          send_request(via_rf_pkg::CMD_PORT_B,
                       via_rf_pkg::reg_t'($urandom_range(via_rf_pkg::REG_ORB,
                                                         via_rf_pkg::REG_ORA_NH)),
                       v);
        end
        sent += 3 + n;
      end else if (choice == 1) begin
        // new edge modes, then a few line changes
        send_request(via_rf_pkg::CMD_WRITE, via_rf_pkg::REG_PCR, 8'($urandom_range(0, 255)));
        repeat (4)
          send_request(via_rf_pkg::cmd_t'($urandom_range(via_rf_pkg::CMD_CA1,
                                                         via_rf_pkg::CMD_CB2)),
                       via_rf_pkg::reg_t'($urandom_range(via_rf_pkg::REG_ORB,
                                                         via_rf_pkg::REG_ORA_NH)),
                       8'($urandom_range(0, 255)));
        sent += 5;
      end else begin
        send_random_request();
        sent++;
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    // predicted state after reset
    port_b_out = '0;
    port_a_out = '0;
    ddr_b = '0;
    ddr_a = '0;
    pin_in_a = '0;
    pin_in_b = '0;
    t1_latch_lo = '0;
    t1_latch_hi = '0;
    shift_value = '0;
    acr = '0;
    pcr = '0;
    flags = '0;
    ora_nh = '0;
    enables = '0;
    t1_counter = via_rf_pkg::TIMER_RESET;
    t2_latch = via_rf_pkg::TIMER_RESET;
    t2_counter = via_rf_pkg::TIMER_RESET;
    t2_counting = 1'b0;
    line_levels = 4'hF;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    test_bus_registers();
    test_control_lines();
    test_timer_side_effects();
    test_backpressure();
    test_random_traffic(600);

    in_valid = 1'b0;
    wait_drained();
    repeat (10) @(posedge clk);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: versatile_interface_register_file.f
+incdir+rtl/core
rtl/core/via_rf_pkg.sv
rtl/core/versatile_interface_register_file.sv
tb/sv/tb.sv
